FILE: hdl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared widths, defaults and status codes of the best-fit bin packer.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int WEIGHT_W        = 16;
  localparam int BIN_INDEX_W     = 6;
  localparam int BINS_USED_W     = 7;
  localparam int STATUS_W        = 2;
  localparam int MAX_BINS_DEFAULT = 64;

  localparam logic [WEIGHT_W-1:0] CAPACITY_RESET = 16'd10;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_PLACED    = 2'd0;
  localparam status_t STATUS_TOO_HEAVY = 2'd1;
  localparam status_t STATUS_NO_SLOT   = 2'd2;

endpackage

FILE: hdl/bfbp_if.sv
// ----------------------------------------------------------------------------
// bfbp_if
// Valid/ready channels of the bin packer: item input and placement result.
// ----------------------------------------------------------------------------
interface bfbp_item_if import bfbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                last_item;

  modport source (output valid, output weight, output last_item, input ready);
  modport sink (input valid, input weight, input last_item, output ready);
endinterface

interface bfbp_result_if import bfbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BIN_INDEX_W-1:0] bin_index;
  logic                   opened_new;
  logic [BINS_USED_W-1:0] bins_used;
  status_t                status;
  logic                   set_done;

  modport source (output valid, output bin_index, output opened_new, output bins_used,
                  output status, output set_done, input ready);
  modport sink (input valid, input bin_index, input opened_new, input bins_used,
                input status, input set_done, output ready);
endinterface

FILE: hdl/best_fit_bin_packer.sv
// ----------------------------------------------------------------------------
// best_fit_bin_packer
// Online best-fit packer: scans the open bins, places each item in the bin
// left with the least room, or opens a new bin, or rejects it.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance the block checks the weight
// against bin_capacity, scans the open bins through the single registered read
// port of the room memory, and writes the chosen bin back as the result is
// registered; it then returns to idle and takes the next item. An item that is
// too heavy skips the scan. The write-back cycle waits while an earlier result
// is still held on the output. The room memory needs no clearing pass: only
// bins below the open count are ever read. The result register holds a
// finished result while the next item is already being scanned.
module best_fit_bin_packer
  import bfbp_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WEIGHT_W-1:0] cfg_data,
  bfbp_item_if.sink           item_in,
  bfbp_result_if.source       result_out
);

  localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BINS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t              state;
  logic [WEIGHT_W-1:0] bin_capacity;
  logic [WEIGHT_W-1:0] weight_reg;
  logic                last_reg;
  logic [CW-1:0]       open_count;
  status_t             status_reg;
  logic [WEIGHT_W-1:0] new_room;

  logic [CW-1:0]       rd_idx;
  logic                rd_pend;
  logic [IW-1:0]       cmp_idx;
  logic                found;
  logic [WEIGHT_W-1:0] best;
  logic [IW-1:0]       best_idx;

  logic [WEIGHT_W-1:0] bin_room [MAX_BINS];
  logic [WEIGHT_W-1:0] rd_data;
  logic                mem_rd_en;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [WEIGHT_W-1:0] mem_wdata;

  // shared subtractor: room - weight during scan, capacity - weight otherwise
  logic [WEIGHT_W-1:0] sub_a;
  logic [WEIGHT_W:0]   sub_diff;
  logic                sub_borrow;

  logic                accept;
  logic                out_free;
  logic                issue;
  logic [CW:0]         count_inc;
  logic [CW-1:0]       count_after;
  logic [IW-1:0]       place_idx;
  logic                place_new;
  status_t             place_status;
  logic [IW+BIN_INDEX_W-1:0] idx_ext;
  logic [CW+BINS_USED_W-1:0] used_ext;

  assign accept   = item_in.valid && item_in.ready;
  assign out_free = !result_out.valid || result_out.ready;
  assign item_in.ready = (state == ST_IDLE);

  assign sub_a      = (state == ST_SCAN) ? rd_data : bin_capacity;
  assign sub_diff   = {1'b0, sub_a} - {1'b0, weight_reg};
  assign sub_borrow = sub_diff[WEIGHT_W];

  assign issue     = (state == ST_SCAN) && (rd_idx < open_count);
  assign mem_rd_en = issue;
  assign count_inc = {1'b0, open_count} + {{CW{1'b0}}, 1'b1};

  // placement decision, made from the scan results
  always_comb begin
    place_idx    = '0;
    place_new    = 1'b0;
    place_status = status_reg;
    count_after  = open_count;
    mem_we       = 1'b0;
    mem_waddr    = best_idx;
    mem_wdata    = best;
    if (status_reg == STATUS_PLACED) begin
      if (found) begin
        place_idx = best_idx;
        mem_we    = 1'b1;
      end else if (open_count < MAX_COUNT) begin
        place_idx   = open_count[IW-1:0];
        place_new   = 1'b1;
        count_after = count_inc[CW-1:0];
        mem_we      = 1'b1;
        mem_waddr   = open_count[IW-1:0];
        mem_wdata   = new_room;
      end else begin
        place_status = STATUS_NO_SLOT;
      end
    end
    if (!((state == ST_DECIDE) && out_free)) begin
      mem_we = 1'b0;
    end
  end

  assign idx_ext  = {{BIN_INDEX_W{1'b0}}, place_idx};
  assign used_ext = {{BINS_USED_W{1'b0}}, count_after};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_room[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_data <= bin_room[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      bin_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      open_count <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      rd_idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          rd_idx  <= '0;
          rd_pend <= 1'b0;
          found   <= 1'b0;
          state   <= sub_borrow ? ST_DECIDE : ST_SCAN;
        end
        ST_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          // later bins win ties
          if (rd_pend && !sub_borrow &&
              (!found || sub_diff[WEIGHT_W-1:0] <= best)) begin
            found <= 1'b1;
          end
          if (!issue) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            open_count <= last_reg ? '0 : count_after;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      weight_reg <= item_in.weight;
      last_reg   <= item_in.last_item;
    end
    if (state == ST_CHECK) begin
      status_reg <= sub_borrow ? STATUS_TOO_HEAVY : STATUS_PLACED;
      new_room   <= sub_diff[WEIGHT_W-1:0];
    end
    if (state == ST_SCAN) begin
      if (issue) begin
        cmp_idx <= rd_idx[IW-1:0];
      end
      if (rd_pend && !sub_borrow && (!found || sub_diff[WEIGHT_W-1:0] <= best)) begin
        best     <= sub_diff[WEIGHT_W-1:0];
        best_idx <= cmp_idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if ((state == ST_DECIDE) && out_free) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DECIDE) && out_free) begin
      result_out.bin_index  <= idx_ext[BIN_INDEX_W-1:0];
      result_out.opened_new <= place_new;
      result_out.bins_used  <= used_ext[BINS_USED_W-1:0];
      result_out.status     <= place_status;
      result_out.set_done   <= last_reg;
    end
  end

`ifndef SYNTH
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CHECK))
    else $error("accepted transaction did not start the weight check");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= MAX_COUNT)
    else $error("open bin count exceeds the number of bin slots");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= open_count))
    else $error("scan ran past the open bins");

  a_unplaced_index: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && (result_out.status != STATUS_PLACED)) |->
      ((result_out.bin_index == '0) && !result_out.opened_new))
    else $error("rejected item reports a bin");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !mem_we)
    else $error("room memory written twice for one item");
`endif

endmodule
